// ===== rtl/scancode_to_ascii_line_editor_defines.svh =====
// ----------------------------------------------------------------------------
// Scan code line editor assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef SCANCODE_TO_ASCII_LINE_EDITOR_DEFINES_SVH
`define SCANCODE_TO_ASCII_LINE_EDITOR_DEFINES_SVH

// same-cycle implication
`define S2A_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define S2A_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/s2a_pkg.sv =====
// ----------------------------------------------------------------------------
// s2a_pkg
// Types, codes and scan code tables for the scan code line editor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package s2a_pkg;

  localparam int LenW        = 8;
  localparam int MaxLine     = 255;
  localparam int DefLineCap  = 256;
  localparam int QDepth      = 2;
  localparam int RomSize     = 58;

  localparam logic [7:0] ScPrefix   = 8'hE0;
  localparam logic [7:0] ScUp       = 8'h48;
  localparam logic [7:0] ScDown     = 8'h50;
  localparam logic [7:0] ScLShift   = 8'h2A;
  localparam logic [7:0] ScRShift   = 8'h36;
  localparam logic [7:0] ScLShiftBr = 8'hAA;
  localparam logic [7:0] ScRShiftBr = 8'hB6;
  localparam logic [7:0] ChBackspc  = 8'h08;
  localparam logic [7:0] ChNewline  = 8'h0A;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_APPEND    = 3'd1,
    EV_ERASE     = 3'd2,
    EV_DONE      = 3'd3,
    EV_HIST_UP   = 3'd4,
    EV_HIST_DOWN = 3'd5,
    EV_GUI       = 3'd6
  } ev_e;

  typedef enum logic [2:0] {
    OP_NONE      = 3'd0,
    OP_CONSUME   = 3'd1,
    OP_HIST_UP   = 3'd2,
    OP_HIST_DOWN = 3'd3,
    OP_GUI       = 3'd4,
    OP_ERASE     = 3'd5,
    OP_DONE      = 3'd6,
    OP_APPEND    = 3'd7
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic       shift;
  } q_entry_t;

  localparam logic [7:0] RomPlain [RomSize] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
    8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
    8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
    8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
    8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  localparam logic [7:0] RomShifted [RomSize] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
    8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
    8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
    8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  function automatic logic [7:0] rom_lookup(input logic shifted, input logic [7:0] code);
    logic [7:0] ch;
    ch = 8'h00;
    if (code < 8'(RomSize)) begin
      ch = shifted ? RomShifted[code[5:0]] : RomPlain[code[5:0]];
    end
    return ch;
  endfunction

endpackage

// ===== rtl/scancode_to_ascii_line_editor.sv =====
// A taken beat is written into the operation queue and reaches the result
// register when the back end pops it. Throughput: one beat per cycle while
// the operation queue is not full; the two-entry operation queue takes up to
// two more beats while the output register is stalled.
// Reset: asynchronous active-low reset clears shift, prefix, length,
// gui mode and queue state; no clearing pass is needed.
// ----------------------------------------------------------------------------
// scancode_to_ascii_line_editor
// Set 1 scan code decoder with shift tracking and a line length editor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scancode_to_ascii_line_editor #(
  parameter int LINE_CAPACITY = s2a_pkg::DefLineCap
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] scan_byte_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] event_res_o,
  output logic [7:0] char_code_o,
  output logic [7:0] position_o,
  output logic [7:0] line_length_o,
  output logic       shift_held_o
);
  import s2a_pkg::*;

  q_entry_t push_entry, pop_entry;
  logic     push, pop, full, empty;

  s2a_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .scan_byte_i (scan_byte_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .entry_o     (push_entry),
    .full_i      (full)
  );

  s2a_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (pop_entry)
  );

  s2a_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .pop_o         (pop),
    .entry_i       (pop_entry),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .event_res_o   (event_res_o),
    .char_code_o   (char_code_o),
    .position_o    (position_o),
    .line_length_o (line_length_o),
    .shift_held_o  (shift_held_o)
  );

endmodule

// ===== rtl/s2a_front.sv =====
// ----------------------------------------------------------------------------
// s2a_front
// Accepts beats, tracks shift and prefix state, decodes into line operations
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2a_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              kind_i,
  input  logic [7:0]        scan_byte_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_data_i,
  output logic              push_o,
  output s2a_pkg::q_entry_t entry_o,
  input  logic              full_i
);
  import s2a_pkg::*;

  logic gui_q;
  logic shift_q, shift_d;
  logic ext_q, ext_d;
  logic accept;
  logic [7:0] ch;
  op_e op;

  assign in_ready_o  = !full_i;
  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign ch          = rom_lookup(shift_q, scan_byte_i);

  always_comb begin
    shift_d = shift_q;
    ext_d   = ext_q;
    op      = OP_NONE;
    if (kind_i) begin
      op = OP_CONSUME;
    end else if (scan_byte_i == ScPrefix) begin
      ext_d = 1'b1;
    end else if (ext_q) begin
      // extended keys never touch shift
      ext_d = 1'b0;
      if (scan_byte_i == ScUp) begin
        op = OP_HIST_UP;
      end else if (scan_byte_i == ScDown) begin
        op = OP_HIST_DOWN;
      end
    end else if (scan_byte_i == ScLShift || scan_byte_i == ScRShift) begin
      shift_d = 1'b1;
    end else if (scan_byte_i == ScLShiftBr || scan_byte_i == ScRShiftBr) begin
      shift_d = 1'b0;
    end else if (scan_byte_i < 8'(RomSize)) begin
      if (gui_q) begin
        op = OP_GUI;
      end else if (ch == ChBackspc) begin
        op = OP_ERASE;
      end else if (ch == ChNewline) begin
        op = OP_DONE;
      end else if (ch != 8'h00) begin
        op = OP_APPEND;
      end
    end
  end

  assign push_o        = accept;
  assign entry_o.op    = op;
  assign entry_o.ch    = ch;
  assign entry_o.shift = shift_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gui_q   <= 1'b0;
      shift_q <= 1'b0;
      ext_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        gui_q <= cfg_data_i;
      end
      if (accept) begin
        shift_q <= shift_d;
        ext_q   <= ext_d;
      end
    end
  end

endmodule

// ===== rtl/s2a_queue.sv =====
// ----------------------------------------------------------------------------
// s2a_queue
// Small FIFO of decoded operations between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2a_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  s2a_pkg::q_entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output s2a_pkg::q_entry_t entry_o
);
  import s2a_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntW = $clog2(QDepth + 1);

  q_entry_t            mem_q [QDepth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/s2a_back.sv =====
// ----------------------------------------------------------------------------
// s2a_back
// Applies line operations to the length count and holds the result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s2a_back #(
  parameter int LINE_CAPACITY = s2a_pkg::DefLineCap
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  output logic              pop_o,
  input  s2a_pkg::q_entry_t entry_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        event_res_o,
  output logic [7:0]        char_code_o,
  output logic [7:0]        position_o,
  output logic [7:0]        line_length_o,
  output logic              shift_held_o
);
  import s2a_pkg::*;
  `include "scancode_to_ascii_line_editor_defines.svh"

  localparam int LimitRaw = LINE_CAPACITY - 1;
  localparam logic [LenW-1:0] LineLimit =
    (LimitRaw > MaxLine) ? LenW'(MaxLine) : LenW'(LimitRaw);

  logic [LenW-1:0] len_q, len_d;
  logic            vld_q;
  ev_e             ev_q, ev_d;
  logic [7:0]      ch_q, ch_d;
  logic [7:0]      pos_q, pos_d;
  logic            shift_q;

  assign pop_o = !empty_i && (!vld_q || out_ready_i);

  always_comb begin
    len_d = len_q;
    ev_d  = EV_NONE;
    ch_d  = 8'h00;
    pos_d = 8'h00;
    case (entry_i.op)
      OP_NONE: ;
      OP_CONSUME: len_d = '0;
      OP_HIST_UP: ev_d = EV_HIST_UP;
      OP_HIST_DOWN: ev_d = EV_HIST_DOWN;
      OP_GUI: begin
        ev_d = EV_GUI;
        ch_d = entry_i.ch;
      end
      OP_ERASE: begin
        // nothing to erase on an empty line
        if (len_q != '0) begin
          len_d = len_q - 1'b1;
          ev_d  = EV_ERASE;
          ch_d  = ChBackspc;
          pos_d = len_q - 1'b1;
        end
      end
      OP_DONE: begin
        ev_d  = EV_DONE;
        pos_d = len_q;
      end
      OP_APPEND: begin
        if (len_q < LineLimit) begin
          ev_d  = EV_APPEND;
          ch_d  = entry_i.ch;
          pos_d = len_q;
          len_d = len_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        len_q <= len_d;
        vld_q <= 1'b1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ev_q    <= ev_d;
      ch_q    <= ch_d;
      pos_q   <= pos_d;
      shift_q <= entry_i.shift;
    end
  end

  assign out_valid_o   = vld_q;
  assign event_res_o   = ev_q;
  assign char_code_o   = ch_q;
  assign position_o    = pos_q;
  assign line_length_o = len_q;
  assign shift_held_o  = shift_q;

  `S2A_ASSERT_IMP(a_len_limit, 1'b1, len_q <= LineLimit, "line length over limit")
  `S2A_ASSERT_NXT(a_pop_shows, pop_o, vld_q, "popped operation not shown")
  `S2A_ASSERT_IMP(a_erase_beat, vld_q && ev_q == EV_ERASE,
                  ch_q == ChBackspc && pos_q == len_q, "erase beat inconsistent")
  `S2A_ASSERT_IMP(a_append_beat, vld_q && ev_q == EV_APPEND,
                  len_q == pos_q + 1'b1 && ch_q != 8'h00, "append beat inconsistent")

endmodule
